[src/kmsc_pkg.sv]
// Package with the matrix geometry, pin numbers, mode codes and request and result types.
`default_nettype none
package kmsc_pkg;

    localparam int MATRIX_ROWS = 11;
    localparam int MATRIX_COLS = 8;
    localparam int NUM_STAGES  = MATRIX_ROWS * MATRIX_COLS;
    localparam int KEY_AW      = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int STAGE_W     = $clog2(NUM_STAGES + 1);
    localparam int DIRECT_ROW  = 10;

    localparam logic [4:0] GPIO_CLK    = 5'd6;
    localparam logic [4:0] GPIO_DATA   = 5'd7;
    localparam logic [4:0] GPIO_KEY_A  = 5'd8;
    localparam logic [4:0] GPIO_KEY_B  = 5'd9;
    localparam logic [4:0] GPIO_KEY_C  = 5'd10;
    localparam logic [4:0] GPIO_RAIL   = 5'd17;
    localparam logic [4:0] GPIO_CAPS   = 5'd18;
    localparam logic [4:0] GPIO_SCROLL = 5'd19;

    typedef enum logic [1:0] {
        MODE_SET_KEY   = 2'd0,
        MODE_PIN_WRITE = 2'd1,
        MODE_PIN_READ  = 2'd2,
        MODE_KEY_QUERY = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] row;
        logic [3:0] col;
        logic       pressed;
        logic [4:0] pin;
        logic       level;
        logic       output_enable;
        logic       data_pad_level;
    } kmsc_in_t;

    typedef struct packed {
        logic        pin_driven;
        logic        pin_level;
        logic [6:0]  selected_stage;
        logic [31:0] clock_pulse_count;
        logic [31:0] reset_count;
        logic [31:0] sense_read_count;
        logic        caps_led_on;
        logic        scroll_led_on;
        logic        panel_powered;
        logic        key_closed;
    } kmsc_out_t;

endpackage
`default_nettype wire

[src/kmsc_if.sv]
// Valid/ready request channels for the input and result streams.
`default_nettype none
interface kmsc_in_if;
    logic               valid;
    logic               ready;
    kmsc_pkg::kmsc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kmsc_out_if;
    logic                valid;
    logic                ready;
    kmsc_pkg::kmsc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/key_matrix_select_chain_top.sv]
// Top level of the shift-register key matrix board model.
// Each request passes through the input register and then the result register, and a new
// request is accepted every cycle while the result side keeps taking them. All state (key
// bits, selected stage, counters and flags) is updated when a request leaves the input
// register, and the result carries the values after that update. The select chain is
// tracked by its lowest set stage alone, which a clock edge moves up by one (stopping one
// past the last stage) or sets to zero.
`default_nettype none
module key_matrix_select_chain_top (
    input  wire        clk,
    input  wire        rst_n,
    kmsc_in_if.sink    in_ch,
    kmsc_out_if.source out_ch
);
    import kmsc_pkg::*;

    logic                  in_valid_reg;
    kmsc_in_t              in_data_reg;
    logic                  out_valid_reg;
    kmsc_out_t             out_data_reg;
    kmsc_out_t             out_data_next;

    logic [NUM_STAGES-1:0] key_bits_reg;
    logic [NUM_STAGES-1:0] key_bits_next;
    logic                  clock_was_high_reg;
    logic                  clock_was_high_next;
    logic [STAGE_W-1:0]    chosen_reg;
    logic [STAGE_W-1:0]    chosen_next;
    logic [31:0]           edge_cnt_reg;
    logic [31:0]           edge_cnt_next;
    logic [31:0]           restart_cnt_reg;
    logic [31:0]           restart_cnt_next;
    logic [31:0]           read_cnt_reg;
    logic [31:0]           read_cnt_next;
    logic                  caps_reg;
    logic                  caps_next;
    logic                  scroll_reg;
    logic                  scroll_next;
    logic                  rail_reg;
    logic                  rail_next;

    logic                  advance;
    logic                  key_ok;
    logic [KEY_AW-1:0]     key_addr;
    logic [8:0]            key_addr_wide;
    logic                  driven;
    logic                  plevel;
    logic                  closed;

    function automatic logic direct_level(input logic [KEY_AW-1:0] idx, input int col,
                                          input logic [NUM_STAGES-1:0] keys);
        logic lvl;
        lvl = 1'b1;
        if (MATRIX_ROWS > DIRECT_ROW && col < MATRIX_COLS)
        begin
            lvl = ~keys[idx];
        end
        return lvl;
    endfunction

    localparam int DIRECT_BASE = DIRECT_ROW * MATRIX_COLS;
    localparam logic [KEY_AW-1:0] DIRECT_A = KEY_AW'(DIRECT_BASE % NUM_STAGES);
    localparam logic [KEY_AW-1:0] DIRECT_B = KEY_AW'((DIRECT_BASE + 1) % NUM_STAGES);
    localparam logic [KEY_AW-1:0] DIRECT_C = KEY_AW'((DIRECT_BASE + 2) % NUM_STAGES);

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign key_ok = (32'(in_data_reg.row) < 32'(MATRIX_ROWS))
                 && (32'(in_data_reg.col) < 32'(MATRIX_COLS));
    assign key_addr_wide = 9'(in_data_reg.row) * 9'(MATRIX_COLS) + 9'(in_data_reg.col);
    assign key_addr      = key_addr_wide[KEY_AW-1:0];

    always_comb
    begin
        key_bits_next       = key_bits_reg;
        clock_was_high_next = clock_was_high_reg;
        chosen_next         = chosen_reg;
        edge_cnt_next       = edge_cnt_reg;
        restart_cnt_next    = restart_cnt_reg;
        read_cnt_next       = read_cnt_reg;
        caps_next           = caps_reg;
        scroll_next         = scroll_reg;
        rail_next           = rail_reg;
        driven              = 1'b0;
        plevel              = 1'b0;
        closed              = 1'b0;

        case (in_data_reg.mode)
            MODE_SET_KEY:
            begin
                if (key_ok)
                begin
                    key_bits_next[key_addr] = in_data_reg.pressed;
                end
            end
            MODE_PIN_WRITE:
            begin
                case (in_data_reg.pin)
                    GPIO_CLK:
                    begin
                        if (in_data_reg.output_enable)
                        begin
                            clock_was_high_next = in_data_reg.level;
                            if (in_data_reg.level && !clock_was_high_reg)
                            begin
                                edge_cnt_next = edge_cnt_reg + 32'd1;
                                if (in_data_reg.data_pad_level)
                                begin
                                    chosen_next = '0;
                                    if (chosen_reg != '0)
                                    begin
                                        restart_cnt_next = restart_cnt_reg + 32'd1;
                                    end
                                end
                                else if (32'(chosen_reg) >= NUM_STAGES - 1)
                                begin
                                    chosen_next = STAGE_W'(NUM_STAGES);
                                end
                                else
                                begin
                                    chosen_next = chosen_reg + STAGE_W'(1);
                                end
                            end
                        end
                    end
                    GPIO_RAIL:   rail_next   = !in_data_reg.level;
                    GPIO_CAPS:   caps_next   = in_data_reg.output_enable && in_data_reg.level;
                    GPIO_SCROLL: scroll_next = in_data_reg.output_enable && in_data_reg.level;
                    default:     ;
                endcase
            end
            MODE_PIN_READ:
            begin
                if (!in_data_reg.output_enable)
                begin
                    case (in_data_reg.pin)
                        GPIO_DATA:
                        begin
                            read_cnt_next = read_cnt_reg + 32'd1;
                            driven        = 1'b1;
                            if (32'(chosen_reg) >= NUM_STAGES)
                            begin
                                plevel = 1'b1;
                            end
                            else
                            begin
                                plevel = ~key_bits_reg[chosen_reg[KEY_AW-1:0]];
                            end
                        end
                        GPIO_KEY_A:
                        begin
                            driven = 1'b1;
                            plevel = direct_level(DIRECT_A, 0, key_bits_reg);
                        end
                        GPIO_KEY_B:
                        begin
                            driven = 1'b1;
                            plevel = direct_level(DIRECT_B, 1, key_bits_reg);
                        end
                        GPIO_KEY_C:
                        begin
                            driven = 1'b1;
                            plevel = direct_level(DIRECT_C, 2, key_bits_reg);
                        end
                        default: ;
                    endcase
                end
            end
            MODE_KEY_QUERY:
            begin
                if (key_ok)
                begin
                    closed = key_bits_reg[key_addr];
                end
            end
            default: ;
        endcase

        out_data_next.pin_driven        = driven;
        out_data_next.pin_level         = plevel;
        out_data_next.selected_stage    = 7'(chosen_next);
        out_data_next.clock_pulse_count = edge_cnt_next;
        out_data_next.reset_count       = restart_cnt_next;
        out_data_next.sense_read_count  = read_cnt_next;
        out_data_next.caps_led_on       = caps_next;
        out_data_next.scroll_led_on     = scroll_next;
        out_data_next.panel_powered     = rail_next;
        out_data_next.key_closed        = closed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            key_bits_reg       <= '0;
            clock_was_high_reg <= 1'b0;
            chosen_reg         <= STAGE_W'(NUM_STAGES);
            edge_cnt_reg       <= '0;
            restart_cnt_reg    <= '0;
            read_cnt_reg       <= '0;
            caps_reg           <= 1'b0;
            scroll_reg         <= 1'b0;
            rail_reg           <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                key_bits_reg       <= key_bits_next;
                clock_was_high_reg <= clock_was_high_next;
                chosen_reg         <= chosen_next;
                edge_cnt_reg       <= edge_cnt_next;
                restart_cnt_reg    <= restart_cnt_next;
                read_cnt_reg       <= read_cnt_next;
                caps_reg           <= caps_next;
                scroll_reg         <= scroll_next;
                rail_reg           <= rail_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_data_reg <= in_ch.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_chosen_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(chosen_reg) <= NUM_STAGES)
        else $error("selected stage beyond the chain length");

    a_restart_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (restart_cnt_reg != $past(restart_cnt_reg)) |-> (chosen_reg == '0))
        else $error("restart count moved without selecting stage zero");

    a_level_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.pin_driven) |-> !out_data_reg.pin_level)
        else $error("pin level high on an undriven pin");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with an empty result register");
`endif

endmodule
`default_nettype wire

[verif/testbench.sv]
// Testbench for key_matrix_select_chain_top: directed table, then random requests.
`timescale 1ns / 1ps
module testbench;
    import kmsc_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 50;

    typedef struct {
        kmsc_in_t  req;
        bit        pinned;
        kmsc_out_t want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    kmsc_in_if  in_ch ();
    kmsc_out_if out_ch ();

    key_matrix_select_chain_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // Board state as the predictor sees it.
    logic [NUM_STAGES-1:0] key_bits;
    logic [NUM_STAGES-1:0] chain_bits;
    logic                  clk_pin_high;
    logic [6:0]            stage;
    logic [31:0]           edges;
    logic [31:0]           restarts;
    logic [31:0]           reads;
    logic                  caps;
    logic                  scroll;
    logic                  rail;

    kmsc_out_t     expected_results[$];
    kmsc_in_t      pending_reqs[$];
    directed_row_t directed_rows[$];
    kmsc_out_t     got_result;
    kmsc_out_t     want_result;
    int            mismatches = 0;
    int            taken = 0;
    int            item_no = 0;
    int            stall_cycles = 0;

    function automatic kmsc_in_t req_of(mode_t m, logic [3:0] r, logic [3:0] c, logic p,
                                        logic [4:0] pin, logic lvl, logic oe, logic pad);
        kmsc_in_t q;
        q.mode           = m;
        q.row            = r;
        q.col            = c;
        q.pressed        = p;
        q.pin            = pin;
        q.level          = lvl;
        q.output_enable  = oe;
        q.data_pad_level = pad;
        return q;
    endfunction

    function automatic kmsc_out_t res_of(logic drv, logic lvl, logic [6:0] stg, logic [31:0] edg,
                                         logic [31:0] rst, logic [31:0] rd, logic cp,
                                         logic sc, logic rl, logic cl);
        kmsc_out_t o;
        o.pin_driven        = drv;
        o.pin_level         = lvl;
        o.selected_stage    = stg;
        o.clock_pulse_count = edg;
        o.reset_count       = rst;
        o.sense_read_count  = rd;
        o.caps_led_on       = cp;
        o.scroll_led_on     = sc;
        o.panel_powered     = rl;
        o.key_closed        = cl;
        return o;
    endfunction

    function automatic kmsc_in_t random_req();
        return req_of(mode_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                      5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic key_present(int r, int c);
        return r < MATRIX_ROWS && c < MATRIX_COLS;
    endfunction

    function automatic kmsc_out_t board_step(kmsc_in_t req);
        kmsc_out_t o;
        logic [6:0] prev;
        logic       rising;
        int         i;
        int         c;
        o = '0;
        case (req.mode)
            MODE_SET_KEY:
            begin
                if (key_present(int'(req.row), int'(req.col)))
                    key_bits[int'(req.row) * MATRIX_COLS + int'(req.col)] = req.pressed;
            end
            MODE_PIN_WRITE:
            begin
                if (req.pin == GPIO_CLK)
                begin
                    if (req.output_enable)
                    begin
                        rising = req.level && !clk_pin_high;
                        clk_pin_high = req.level;
                        if (rising)
                        begin
                            prev = stage;
                            chain_bits = {chain_bits[NUM_STAGES-2:0], req.data_pad_level};
                            edges = edges + 1;
                            stage = 7'(NUM_STAGES);
                            for (i = NUM_STAGES - 1; i >= 0; i--)
                                if (chain_bits[i])
                                    stage = 7'(i);
                            if (stage != prev && stage == 0)
                                restarts = restarts + 1;
                        end
                    end
                end
                else if (req.pin == GPIO_RAIL)
                    rail = !req.level;
                else if (req.pin == GPIO_CAPS)
                    caps = req.output_enable && req.level;
                else if (req.pin == GPIO_SCROLL)
                    scroll = req.output_enable && req.level;
            end
            MODE_PIN_READ:
            begin
                if (!req.output_enable)
                begin
                    if (req.pin == GPIO_DATA)
                    begin
                        reads = reads + 1;
                        o.pin_driven = 1'b1;
                        o.pin_level = (stage >= NUM_STAGES) ? 1'b1 : !key_bits[stage];
                    end
                    else if (req.pin == GPIO_KEY_A || req.pin == GPIO_KEY_B ||
                             req.pin == GPIO_KEY_C)
                    begin
                        c = int'(req.pin) - int'(GPIO_KEY_A);
                        o.pin_driven = 1'b1;
                        o.pin_level = key_present(DIRECT_ROW, c) ?
                                      !key_bits[DIRECT_ROW * MATRIX_COLS + c] : 1'b1;
                    end
                end
            end
            MODE_KEY_QUERY:
            begin
                if (key_present(int'(req.row), int'(req.col)))
                    o.key_closed = key_bits[int'(req.row) * MATRIX_COLS + int'(req.col)];
            end
        endcase
        o.selected_stage    = stage;
        o.clock_pulse_count = edges;
        o.reset_count       = restarts;
        o.sense_read_count  = reads;
        o.caps_led_on       = caps;
        o.scroll_led_on     = scroll;
        o.panel_powered     = rail;
        return o;
    endfunction

    function automatic void add_row(kmsc_in_t req, bit pinned, kmsc_out_t want);
        directed_row_t d;
        d.req    = req;
        d.pinned = pinned;
        d.want   = want;
        directed_rows.push_back(d);
    endfunction

    function automatic void push_clock_pair(logic pad);
        kmsc_in_t q;
        q = random_req();
        q.mode = MODE_PIN_WRITE;
        q.pin = GPIO_CLK;
        q.level = 1'b0;
        q.output_enable = ($urandom_range(0, 9) != 0);
        pending_reqs.push_back(q);
        q = random_req();
        q.mode = MODE_PIN_WRITE;
        q.pin = GPIO_CLK;
        q.level = 1'b1;
        q.output_enable = ($urandom_range(0, 9) != 0);
        q.data_pad_level = pad;
        pending_reqs.push_back(q);
    endfunction

    function automatic void plan_sequence(bit sweep);
        kmsc_in_t q;
        int       kind;
        int       pad_pct;
        int       i;
        q = random_req();
        kind = $urandom_range(0, 99);
        pad_pct = ($urandom_range(0, 3) == 0) ? 50 : 5;
        if (sweep)
        begin
            // One set bit followed by a long run of empty shifts walks the selection off
            // the far end of the chain.
            push_clock_pair(1'b1);
            for (i = 0; i < NUM_STAGES + 2; i++)
                push_clock_pair(1'b0);
            foreach (pending_reqs[j])
                pending_reqs[j].output_enable = 1'b1;
            q.mode = MODE_PIN_READ;
            q.pin = GPIO_DATA;
            q.output_enable = 1'b0;
        end
        else if (kind < 30)
        begin
            push_clock_pair($urandom_range(0, 99) < pad_pct);
            q.mode = MODE_PIN_READ;
            q.pin = GPIO_DATA;
            q.output_enable = ($urandom_range(0, 9) == 0);
        end
        else if (kind < 45)
        begin
            q.mode = MODE_PIN_READ;
            q.pin = GPIO_DATA;
            q.output_enable = ($urandom_range(0, 9) == 0);
        end
        else if (kind < 60 || kind < 70)
        begin
            q.mode = (kind < 60) ? MODE_SET_KEY : MODE_KEY_QUERY;
            if ($urandom_range(0, 9) != 0)
            begin
                q.row = 4'($urandom_range(0, MATRIX_ROWS - 1));
                q.col = 4'($urandom_range(0, MATRIX_COLS - 1));
            end
        end
        else if (kind < 78)
        begin
            q.mode = MODE_PIN_READ;
            q.pin = 5'($urandom_range(int'(GPIO_KEY_A), int'(GPIO_KEY_C)));
            q.output_enable = ($urandom_range(0, 9) == 0);
        end
        else if (kind < 86)
        begin
            q.mode = MODE_PIN_WRITE;
            case ($urandom_range(0, 2))
                0: q.pin = GPIO_RAIL;
                1: q.pin = GPIO_CAPS;
                default: q.pin = GPIO_SCROLL;
            endcase
        end
        pending_reqs.push_back(q);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("result %0d: %s is %0h, expected %0h", taken, what, got, want);
        mismatches++;
    endtask

    task automatic send_req(kmsc_in_t req, bit pinned, kmsc_out_t want);
        kmsc_out_t predicted;
        bit        steady;
        steady = item_no >= 400 && item_no < 650;
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= req;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = board_step(req);
        expected_results.push_back(pinned ? want : predicted);
        item_no++;
    endtask

    initial
    begin
        kmsc_out_t none;
        int        sent;
        bit        swept;
        none = '0;
        sent = 0;
        swept = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        key_bits = '0;
        chain_bits = '0;
        clk_pin_high = 1'b0;
        stage = 7'(NUM_STAGES);
        edges = '0;
        restarts = '0;
        reads = '0;
        caps = 1'b0;
        scroll = 1'b0;
        rail = 1'b0;

        add_row(req_of(MODE_KEY_QUERY, 0, 0, 0, 0, 0, 0, 0), 1,
                res_of(0, 0, 88, 0, 0, 0, 0, 0, 0, 0));
        add_row(req_of(MODE_PIN_READ, 0, 0, 0, GPIO_DATA, 0, 0, 0), 1,
                res_of(1, 1, 88, 0, 0, 1, 0, 0, 0, 0));
        add_row(req_of(MODE_PIN_READ, 0, 0, 0, GPIO_DATA, 0, 1, 0), 1,
                res_of(0, 0, 88, 0, 0, 1, 0, 0, 0, 0));
        add_row(req_of(MODE_SET_KEY, 10, 0, 1, 0, 0, 0, 0), 0, none);
        add_row(req_of(MODE_SET_KEY, 10, 2, 1, 0, 0, 0, 0), 0, none);
        add_row(req_of(MODE_SET_KEY, 11, 0, 1, 0, 0, 0, 0), 0, none);
        add_row(req_of(MODE_SET_KEY, 0, 8, 1, 0, 0, 0, 0), 0, none);
        add_row(req_of(MODE_PIN_READ, 0, 0, 0, GPIO_KEY_A, 0, 0, 0), 1,
                res_of(1, 0, 88, 0, 0, 1, 0, 0, 0, 0));
        add_row(req_of(MODE_PIN_READ, 0, 0, 0, GPIO_KEY_B, 0, 0, 0), 1,
                res_of(1, 1, 88, 0, 0, 1, 0, 0, 0, 0));
        add_row(req_of(MODE_PIN_READ, 0, 0, 0, GPIO_KEY_C, 0, 0, 0), 1,
                res_of(1, 0, 88, 0, 0, 1, 0, 0, 0, 0));
        add_row(req_of(MODE_KEY_QUERY, 15, 15, 1, 31, 1, 1, 1), 1,
                res_of(0, 0, 88, 0, 0, 1, 0, 0, 0, 0));
        add_row(req_of(MODE_KEY_QUERY, 10, 0, 0, 0, 0, 0, 0), 1,
                res_of(0, 0, 88, 0, 0, 1, 0, 0, 0, 1));
        add_row(req_of(MODE_SET_KEY, 0, 0, 1, 0, 0, 0, 0), 0, none);
        add_row(req_of(MODE_SET_KEY, 10, 7, 1, 0, 0, 0, 0), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_CLK, 1, 0, 1), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_CLK, 1, 1, 1), 1,
                res_of(0, 0, 0, 1, 1, 1, 0, 0, 0, 0));
        add_row(req_of(MODE_PIN_READ, 0, 0, 0, GPIO_DATA, 0, 0, 0), 1,
                res_of(1, 0, 0, 1, 1, 2, 0, 0, 0, 0));
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_CLK, 1, 1, 0), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_CLK, 0, 1, 0), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_CLK, 1, 1, 0), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_RAIL, 0, 1, 0), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_CAPS, 1, 1, 0), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_SCROLL, 1, 0, 0), 0, none);
        add_row(req_of(MODE_PIN_WRITE, 0, 0, 0, GPIO_DATA, 1, 1, 1), 0, none);
        add_row(req_of(MODE_PIN_READ, 0, 0, 0, 31, 0, 0, 0), 0, none);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);

        while (sent < RANDOM_ITEMS)
        begin
            if (pending_reqs.size() == 0)
            begin
                plan_sequence(!swept && sent >= 300);
                if (!swept && sent >= 300)
                    swept = 1'b1;
            end
            send_req(pending_reqs.pop_front(), 0, none);
            sent++;
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS key_matrix_select_chain_top");
        else
            $display("FAIL key_matrix_select_chain_top");
        $finish;
    end

    // Result side: random back-pressure, a quiet stretch, and one long hold-off.
    initial
    begin
        bit held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && taken >= 150)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ch.ready <= (taken >= 400 && taken < 650) || ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            taken <= taken + 1;
            got_result = out_ch.data;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", '0, '0);
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result.pin_driven !== want_result.pin_driven)
                    report_mismatch("pin_driven", 32'(got_result.pin_driven),
                                    32'(want_result.pin_driven));
                if (got_result.pin_level !== want_result.pin_level)
                    report_mismatch("pin_level", 32'(got_result.pin_level),
                                    32'(want_result.pin_level));
                if (got_result.selected_stage !== want_result.selected_stage)
                    report_mismatch("selected_stage", 32'(got_result.selected_stage),
                                    32'(want_result.selected_stage));
                if (got_result.clock_pulse_count !== want_result.clock_pulse_count)
                    report_mismatch("clock_pulse_count", got_result.clock_pulse_count,
                                    want_result.clock_pulse_count);
                if (got_result.reset_count !== want_result.reset_count)
                    report_mismatch("reset_count", got_result.reset_count,
                                    want_result.reset_count);
                if (got_result.sense_read_count !== want_result.sense_read_count)
                    report_mismatch("sense_read_count", got_result.sense_read_count,
                                    want_result.sense_read_count);
                if (got_result.caps_led_on !== want_result.caps_led_on)
                    report_mismatch("caps_led_on", 32'(got_result.caps_led_on),
                                    32'(want_result.caps_led_on));
                if (got_result.scroll_led_on !== want_result.scroll_led_on)
                    report_mismatch("scroll_led_on", 32'(got_result.scroll_led_on),
                                    32'(want_result.scroll_led_on));
                if (got_result.panel_powered !== want_result.panel_powered)
                    report_mismatch("panel_powered", 32'(got_result.panel_powered),
                                    32'(want_result.panel_powered));
                if (got_result.key_closed !== want_result.key_closed)
                    report_mismatch("key_closed", 32'(got_result.key_closed),
                                    32'(want_result.key_closed));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("FAIL key_matrix_select_chain_top");
            $finish;
        end
    end

endmodule
